FILE: rtl/x86s_pkg.sv
`default_nettype none
package x86s_pkg;

    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_EXEC    = 3'd1,
        ST_PORT    = 3'd2,
        ST_INT     = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_HALTED  = 3'd5
    } t_status;

    localparam logic [15:0] RESET_AX = 16'h5555;
    localparam logic [15:0] RESET_CX = 16'h0001;
    localparam logic [15:0] RESET_BX = 16'h7c00;
    localparam logic [15:0] RESET_SP = 16'h0100;
    localparam logic [15:0] RESET_DI = 16'hfffe;
    localparam logic [15:0] RESET_SS = 16'h7000;
    localparam logic [15:0] RESET_FL = 16'h0200;

    localparam logic [2:0] R_AX = 3'd0;
    localparam logic [2:0] R_DX = 3'd2;
    localparam logic [2:0] R_SP = 3'd4;
    localparam logic [1:0] S_CS = 2'd1;
    localparam logic [1:0] S_SS = 2'd2;
    localparam logic [1:0] S_DS = 2'd3;

    localparam logic [7:0] OP_NOP   = 8'h90;
    localparam logic [7:0] OP_CLI   = 8'hfa;
    localparam logic [7:0] OP_STI   = 8'hfb;
    localparam logic [7:0] OP_JMP   = 8'heb;
    localparam logic [7:0] OP_JC    = 8'h72;
    localparam logic [7:0] OP_CALL  = 8'he8;
    localparam logic [7:0] OP_PUSHF = 8'h9c;
    localparam logic [7:0] OP_POPF  = 8'h9d;
    localparam logic [7:0] OP_MOVRR = 8'h8b;
    localparam logic [7:0] OP_MOVRS = 8'h8c;
    localparam logic [7:0] OP_MOVSR = 8'h8e;
    localparam logic [7:0] OP_LDAX  = 8'ha1;
    localparam logic [7:0] OP_OUTIB = 8'he6;
    localparam logic [7:0] OP_OUTIW = 8'he7;
    localparam logic [7:0] OP_OUTDB = 8'hee;
    localparam logic [7:0] OP_OUTDW = 8'hef;
    localparam logic [7:0] OP_INT   = 8'hcd;

    // Instruction classes chosen by the decoder after the opcode fetch.
    typedef enum logic [4:0] {
        K_NOP, K_CLI, K_STI, K_JMP, K_JC, K_CALL, K_PUSHR, K_POPR, K_PUSHS, K_POPS,
        K_PUSHF, K_POPF, K_MOVX, K_LDAX, K_MOVB, K_MOVW, K_OUTI, K_OUTD, K_INT, K_BAD
    } t_kind;

    function automatic t_kind decode(input logic [7:0] op);
        t_kind k;
        k = K_BAD;
        unique case (op) inside
            [8'h50:8'h57]: k = K_PUSHR;
            [8'h58:8'h5f]: k = K_POPR;
            [8'hb0:8'hb7]: k = K_MOVB;
            [8'hb8:8'hbf]: k = K_MOVW;
            8'h06, 8'h0e, 8'h16, 8'h1e: k = K_PUSHS;
            8'h07, 8'h0f, 8'h17, 8'h1f: k = K_POPS;
            OP_NOP, 8'h26, 8'h2e, 8'h36, 8'h3e, 8'h66, 8'h67, 8'hf0, 8'hf2, 8'hf3:
                k = K_NOP;
            OP_CLI: k = K_CLI;
            OP_STI: k = K_STI;
            OP_JMP: k = K_JMP;
            OP_JC: k = K_JC;
            OP_CALL: k = K_CALL;
            OP_PUSHF: k = K_PUSHF;
            OP_POPF: k = K_POPF;
            OP_MOVRR, OP_MOVRS, OP_MOVSR: k = K_MOVX;
            OP_LDAX: k = K_LDAX;
            OP_OUTIB, OP_OUTIW: k = K_OUTI;
            OP_OUTDB, OP_OUTDW: k = K_OUTD;
            OP_INT: k = K_INT;
            default: k = K_BAD;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/x86s_mem.sv
`default_nettype none
module x86s_mem #(
    parameter int MEM_BYTES = 131072
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [$clog2(MEM_BYTES)-1:0]  i_addr,
    input  wire [7:0]                    i_wdata,
    output logic [7:0]                   o_rdata
);
    logic [7:0] r_mem [MEM_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/x86_subset_instruction_executor.sv
`default_nettype none
// Executor for a small 8086 subset working from an internal byte memory.
// Slave channel: one transfer is either a memory byte load (tdata action 0)
// or a request to run one instruction at CS:IP (action 1). Master channel:
// one result transfer per input transfer carrying status, OUT port and value,
// INT vector, and CS and IP after the step.
// An instruction fetches its opcode and operand bytes, then pushes stack
// bytes or reads popped or data bytes, one memory byte per access. The
// single byte-wide memory port has registered read data, and the address
// adder is shared by every fetch, stack and data access. One item is
// worked on at a time: s_axis_tready is low from acceptance until the cycle
// after the result has been taken.
// Reset restores the architectural registers (AX 5555h, BX 7C00h, CX 1,
// SP 100h, DI FFFEh, SS 7000h, flags 0200h) and clears the halt flag; memory
// is not cleared and must be loaded before use. When the receiver stalls,
// the result is held in the output register and no new input is taken.
module x86_subset_instruction_executor #(
    parameter int MEM_BYTES = 131072
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // action[0], load_address[17:1], load_data[25:18]
    input  wire  [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status[2:0], out_port[18:3], out_value[34:19], int_vector[42:35],
    // code_segment[58:43], instr_pointer[74:59]
    output logic [79:0] m_axis_tdata
);
    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_OPC   = 9'b000000100,
        S_DEC   = 9'b000001000,
        S_ACC   = 9'b000010000,
        S_WAIT  = 9'b000100000,
        S_EXEC  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_RD    = 9'b100000000
    } t_state;

    // Access kinds for the sequenced memory operations.
    typedef enum logic [1:0] {A_FETCH, A_PUSH, A_POP, A_DATA} t_acc;

    t_state r_state, n_state;
    logic [15:0] r_gr [8];
    logic [15:0] r_sr [4];
    logic [15:0] r_ip, r_fl;
    logic        r_halt;
    logic [7:0]  r_op;
    x86s_pkg::t_kind r_kind;
    logic [7:0]  r_b [4];      // collected bytes: fetched operands, then popped/data bytes
    logic [2:0]  r_nf;         // operand bytes still to fetch
    logic [2:0]  r_cnt;        // bytes gathered
    logic [1:0]  r_np;         // stack pushes (bytes) remaining
    logic [1:0]  r_nr;         // pops or data reads (bytes) remaining
    logic [15:0] r_pv;         // value being pushed
    t_acc        r_acc;
    logic [AW-1:0] r_addr;
    logic          r_we;
    logic [7:0]    r_wd;
    logic [7:0]    w_rd;
    logic [79:0]   r_out;
    logic          r_ov;

    x86s_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(r_we), .i_addr(r_addr), .i_wdata(r_wd), .o_rdata(w_rd)
    );

    // Shared physical address adder.
    logic [15:0] w_seg, w_off;
    logic [19:0] w_lin;
    logic [AW-1:0] w_phys;
    always_comb begin
        w_lin  = {w_seg, 4'd0} + {4'd0, w_off};
        w_phys = (AW >= 20) ? AW'(w_lin) : w_lin[AW-1:0];
    end

    function automatic logic [15:0] sx(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    // Choose the next access and its segment:offset.
    always_comb begin
        w_seg = r_sr[x86s_pkg::S_CS];
        w_off = r_ip;
        if (r_state == S_IDLE || r_nf != 3'd0) begin
            w_seg = r_sr[x86s_pkg::S_CS]; w_off = r_ip;
        end else if (r_np != 2'd0) begin
            w_seg = r_sr[x86s_pkg::S_SS];
            w_off = r_gr[x86s_pkg::R_SP] - ((r_np == 2'd2) ? 16'd2 : 16'd1);
        end else if (r_kind == x86s_pkg::K_LDAX) begin
            w_seg = r_sr[x86s_pkg::S_DS];
            w_off = {r_b[1], r_b[0]} + ((r_nr == 2'd2) ? 16'd0 : 16'd1);
        end else begin
            w_seg = r_sr[x86s_pkg::S_SS];
            w_off = r_gr[x86s_pkg::R_SP] + ((r_nr == 2'd2) ? 16'd0 : 16'd1);
        end
    end

    wire w_in  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // A memory write is issued for a load and for each pushed stack byte.
    always_ff @(posedge i_clk) begin
        r_we <= i_rst_n && ((w_in && !s_axis_tdata[0])
                            || (r_state == S_ACC && r_nf == 3'd0 && r_np != 2'd0));
    end

    logic [2:0] w_reg;
    logic [1:0] w_sg;
    logic [7:0] w_m;
    assign w_reg = r_op[2:0];
    assign w_sg  = r_op[4:3];
    assign w_m   = r_b[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            r_halt <= 1'b0;
            r_gr[0] <= x86s_pkg::RESET_AX;
            r_gr[1] <= x86s_pkg::RESET_CX;
            r_gr[2] <= 16'd0;
            r_gr[3] <= x86s_pkg::RESET_BX;
            r_gr[4] <= x86s_pkg::RESET_SP;
            r_gr[5] <= 16'd0;
            r_gr[6] <= 16'd0;
            r_gr[7] <= x86s_pkg::RESET_DI;
            r_sr[0] <= 16'd0;
            r_sr[1] <= 16'd0;
            r_sr[x86s_pkg::S_SS] <= x86s_pkg::RESET_SS;
            r_sr[3] <= 16'd0;
            r_ip <= 16'd0;
            r_fl <= x86s_pkg::RESET_FL;
            r_nf <= 3'd0; r_np <= 2'd0; r_nr <= 2'd0; r_cnt <= 3'd0;
        end else begin
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_in) begin
                    if (!s_axis_tdata[0]) begin
                        r_addr  <= (AW >= 17) ? AW'(s_axis_tdata[17:1])
                                              : s_axis_tdata[AW:1];
                        r_wd    <= s_axis_tdata[25:18];
                        r_state <= S_LOAD;
                    end else if (r_halt) begin
                        r_out <= {5'd0, r_ip, r_sr[x86s_pkg::S_CS], 8'd0, 16'd0, 16'd0,
                                  x86s_pkg::ST_HALTED};
                        r_state <= S_OUT;
                    end else begin
                        r_addr  <= w_phys;
                        r_ip    <= r_ip + 16'd1;
                        r_state <= S_OPC;
                    end
                end
                S_LOAD: begin
                    r_out <= {5'd0, r_ip, r_sr[x86s_pkg::S_CS], 8'd0, 16'd0, 16'd0,
                              x86s_pkg::ST_LOADED};
                    r_state <= S_OUT;
                end
                S_OPC: r_state <= S_DEC;   // memory read latency
                S_DEC: begin
                    x86s_pkg::t_kind k;
                    k = x86s_pkg::decode(w_rd);
                    r_op <= w_rd; r_kind <= k; r_cnt <= 3'd0;
                    r_nf <= 3'd0; r_np <= 2'd0; r_nr <= 2'd0;
                    case (k)
                        x86s_pkg::K_JMP, x86s_pkg::K_JC, x86s_pkg::K_MOVX, x86s_pkg::K_MOVB,
                        x86s_pkg::K_OUTI, x86s_pkg::K_INT: r_nf <= 3'd1;
                        x86s_pkg::K_MOVW: r_nf <= 3'd2;
                        x86s_pkg::K_LDAX: begin r_nf <= 3'd2; r_nr <= 2'd2; end
                        x86s_pkg::K_CALL: begin r_nf <= 3'd2; r_np <= 2'd2; end
                        x86s_pkg::K_PUSHR: begin r_np <= 2'd2; r_pv <= r_gr[w_rd[2:0]]; end
                        x86s_pkg::K_PUSHS: begin r_np <= 2'd2; r_pv <= r_sr[w_rd[4:3]]; end
                        x86s_pkg::K_PUSHF: begin r_np <= 2'd2; r_pv <= r_fl; end
                        x86s_pkg::K_POPR, x86s_pkg::K_POPS, x86s_pkg::K_POPF: r_nr <= 2'd2;
                        default: ;
                    endcase
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_nf != 3'd0) begin
                        r_addr <= w_phys; r_ip <= r_ip + 16'd1; r_nf <= r_nf - 3'd1;
                        r_acc <= A_FETCH; r_state <= S_RD;
                        // The call return address is the IP after the displacement.
                        if (r_kind == x86s_pkg::K_CALL && r_nf == 3'd1)
                            r_pv <= r_ip + 16'd1;
                    end else if (r_np != 2'd0) begin
                        r_addr <= w_phys;
                        r_wd <= (r_np == 2'd2) ? r_pv[7:0] : r_pv[15:8];
                        r_np <= r_np - 2'd1; r_acc <= A_PUSH;
                        if (r_np == 2'd1)
                            r_gr[x86s_pkg::R_SP] <= r_gr[x86s_pkg::R_SP] - 16'd2;
                        r_state <= S_ACC;
                    end else if (r_nr != 2'd0) begin
                        r_addr <= w_phys; r_nr <= r_nr - 2'd1;
                        r_acc <= (r_kind == x86s_pkg::K_LDAX) ? A_DATA : A_POP;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_RD: r_state <= S_WAIT;   // memory read latency
                S_WAIT: begin
                    r_state <= S_ACC;
                    if (r_acc == A_FETCH) begin
                        r_b[r_cnt[1:0]] <= w_rd; r_cnt <= r_cnt + 3'd1;
                    end else begin
                        r_b[{1'b1, r_nr == 2'd0}] <= w_rd;
                    end
                end
                S_EXEC: begin
                    logic [15:0] ip;
                    logic [15:0] imm;
                    logic [15:0] pv;
                    logic [2:0]  st;
                    logic [15:0] prt, val;
                    logic [7:0]  vec;
                    ip = r_ip; imm = {r_b[1], r_b[0]}; pv = {r_b[3], r_b[2]};
                    st = x86s_pkg::ST_EXEC; prt = 16'd0; val = 16'd0; vec = 8'd0;
                    case (r_kind)
                        x86s_pkg::K_CLI: r_fl <= r_fl & 16'hfdff;
                        x86s_pkg::K_STI: r_fl <= r_fl | 16'h0200;
                        x86s_pkg::K_JMP: ip = r_ip + sx(r_b[0]);
                        x86s_pkg::K_JC: if (r_fl[0]) ip = r_ip + sx(r_b[0]);
                        x86s_pkg::K_CALL: ip = r_ip + imm;
                        x86s_pkg::K_POPR: begin
                            // POP SP leaves SP holding the popped value.
                            if (w_reg != x86s_pkg::R_SP)
                                r_gr[x86s_pkg::R_SP] <= r_gr[x86s_pkg::R_SP] + 16'd2;
                            r_gr[w_reg] <= pv;
                        end
                        x86s_pkg::K_POPS: begin
                            r_gr[x86s_pkg::R_SP] <= r_gr[x86s_pkg::R_SP] + 16'd2;
                            r_sr[w_sg] <= pv;
                        end
                        x86s_pkg::K_POPF: begin
                            r_gr[x86s_pkg::R_SP] <= r_gr[x86s_pkg::R_SP] + 16'd2;
                            r_fl <= pv;
                        end
                        x86s_pkg::K_MOVX: begin
                            if (w_m[7:6] != 2'b11) begin
                                r_halt <= 1'b1; st = x86s_pkg::ST_UNKNOWN;
                            end else if (r_op == x86s_pkg::OP_MOVRR) begin
                                r_gr[w_m[5:3]] <= r_gr[w_m[2:0]];
                            end else if (r_op == x86s_pkg::OP_MOVRS) begin
                                r_gr[w_m[2:0]] <= r_sr[w_m[4:3]];
                            end else begin
                                r_sr[w_m[4:3]] <= r_gr[w_m[2:0]];
                            end
                        end
                        x86s_pkg::K_LDAX: r_gr[x86s_pkg::R_AX] <= pv;
                        x86s_pkg::K_MOVB: begin
                            if (r_op[2])
                                r_gr[{1'b0, r_op[1:0]}][15:8] <= r_b[0];
                            else
                                r_gr[{1'b0, r_op[1:0]}][7:0] <= r_b[0];
                        end
                        x86s_pkg::K_MOVW: r_gr[w_reg] <= imm;
                        x86s_pkg::K_OUTI, x86s_pkg::K_OUTD: begin
                            st  = x86s_pkg::ST_PORT;
                            prt = (r_kind == x86s_pkg::K_OUTI) ? {8'd0, r_b[0]}
                                                               : r_gr[x86s_pkg::R_DX];
                            val = r_op[0] ? r_gr[x86s_pkg::R_AX]
                                          : {8'd0, r_gr[x86s_pkg::R_AX][7:0]};
                        end
                        x86s_pkg::K_INT: begin st = x86s_pkg::ST_INT; vec = r_b[0]; end
                        x86s_pkg::K_BAD: begin r_halt <= 1'b1; st = x86s_pkg::ST_UNKNOWN; end
                        default: ;
                    endcase
                    r_ip <= ip;
                    // CS may change only by POP CS or MOV CS, so take the new value.
                    r_out <= {5'd0, ip,
                              ((r_kind == x86s_pkg::K_POPS && w_sg == x86s_pkg::S_CS) ? pv :
                               (r_kind == x86s_pkg::K_MOVX && r_op == x86s_pkg::OP_MOVSR &&
                                w_m[7:6] == 2'b11 && w_m[4:3] == x86s_pkg::S_CS)
                                   ? r_gr[w_m[2:0]] : r_sr[x86s_pkg::S_CS]),
                              vec, val, prt, st};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                    end else if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb_x86_subset_instruction_executor.sv
`default_nettype none
module tb_x86_subset_instruction_executor;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEMB = 131072;
    localparam int RUN_STEPS = 600;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EXEC = 1'b1;

    // Opcode groups that the package does not name.
    localparam logic [4:0] GRP_PUSHR = 5'b01010;
    localparam logic [4:0] GRP_POPR  = 5'b01011;
    localparam logic [4:0] GRP_MOVB  = 5'b10110;
    localparam logic [4:0] GRP_MOVW  = 5'b10111;
    localparam logic [2:0] LOW_PUSHS = 3'd6;
    localparam logic [2:0] LOW_POPS  = 3'd7;
    localparam logic [7:0] OP_PUSH_AX = 8'h50;
    localparam logic [7:0] OP_PUSH_ES = 8'h06;
    localparam logic [7:0] OP_POP_CS  = 8'h0f;
    localparam logic [7:0] OP_MOVB_AL = 8'hb0;
    localparam logic [7:0] OP_MOVW_AX = 8'hb8;
    localparam logic [7:0] PFX_REP    = 8'hf3;
    localparam logic [1:0] MOD_REG    = 2'b11;
    localparam logic [2:0] R_BX_TB    = 3'd3;

    typedef struct packed {
        x86s_pkg::t_status st;
        logic [15:0] port;
        logic [15:0] value;
        logic [7:0]  vec;
        logic [15:0] cs;
        logic [15:0] ip;
    } t_step_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    x86_subset_instruction_executor uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow machine state.
    logic [7:0]  mem [0:MEMB-1];
    bit          written [0:MEMB-1];
    logic [15:0] gpr [8];
    logic [15:0] seg [4];
    logic [15:0] ip_q, flags_q;
    bit          halted_q;
    int          first_miss;

    t_step_result pending_results[$];
    int  errors = 0;
    int  seen_status[8];
    bit  quiet = 1'b0;
    int  rx_stall = 0;
    longint cycles = 0;

    function automatic logic [16:0] phys(input logic [15:0] s, input logic [15:0] o);
        logic [20:0] t;
        t = {1'b0, s, 4'b0} + {5'b0, o};
        return t[16:0];
    endfunction

    function automatic logic [7:0] rd8(input logic [16:0] a);
        if (!written[a]) begin
            if (first_miss < 0) first_miss = int'(a);
            return 8'h00;
        end
        return mem[a];
    endfunction

    function automatic logic [7:0] fetch8();
        logic [7:0] b;
        b = rd8(phys(seg[x86s_pkg::S_CS], ip_q));
        ip_q = ip_q + 16'd1;
        return b;
    endfunction

    function automatic logic [15:0] fetch16();
        logic [7:0] lo;
        lo = fetch8();
        return {fetch8(), lo};
    endfunction

    function automatic void push_word(input logic [15:0] v, input bit dry);
        logic [15:0] sp;
        sp = gpr[x86s_pkg::R_SP] - 16'd2;
        gpr[x86s_pkg::R_SP] = sp;
        if (!dry) begin
            mem[phys(seg[x86s_pkg::S_SS], sp)] = v[7:0];
            written[phys(seg[x86s_pkg::S_SS], sp)] = 1'b1;
            mem[phys(seg[x86s_pkg::S_SS], sp + 16'd1)] = v[15:8];
            written[phys(seg[x86s_pkg::S_SS], sp + 16'd1)] = 1'b1;
        end
    endfunction

    function automatic logic [15:0] pop_word();
        logic [7:0] lo, hi;
        lo = rd8(phys(seg[x86s_pkg::S_SS], gpr[x86s_pkg::R_SP]));
        hi = rd8(phys(seg[x86s_pkg::S_SS], gpr[x86s_pkg::R_SP] + 16'd1));
        gpr[x86s_pkg::R_SP] = gpr[x86s_pkg::R_SP] + 16'd2;
        return {hi, lo};
    endfunction

    function automatic logic [15:0] sext(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    // Advances the shadow machine by one input transfer. With dry set, no
    // memory is written; the caller restores the registers afterwards.
    function automatic t_step_result run_step(input logic [31:0] d, input bit dry);
        t_step_result r;
        logic [7:0] op, m;
        logic [15:0] w, a;
        r = '0;
        r.st = x86s_pkg::ST_EXEC;
        if (d[0] == ACT_LOAD) begin
            if (!dry) begin
                mem[d[17:1]] = d[25:18];
                written[d[17:1]] = 1'b1;
            end
            r.st = x86s_pkg::ST_LOADED;
        end else if (halted_q) begin
            r.st = x86s_pkg::ST_HALTED;
        end else begin
            op = fetch8();
            if (op[7:3] == GRP_PUSHR) begin
                push_word(gpr[op[2:0]], dry);
            end else if (op[7:3] == GRP_POPR) begin
                gpr[op[2:0]] = pop_word();
            end else if (op[7:3] == GRP_MOVB) begin
                m = fetch8();
                if (op[2]) gpr[op[1:0]][15:8] = m;
                else gpr[op[1:0]][7:0] = m;
            end else if (op[7:3] == GRP_MOVW) begin
                gpr[op[2:0]] = fetch16();
            end else if (op[7:5] == 3'd0 && op[2:0] == LOW_PUSHS) begin
                push_word(seg[op[4:3]], dry);
            end else if (op[7:5] == 3'd0 && op[2:0] == LOW_POPS) begin
                seg[op[4:3]] = pop_word();
            end else begin
                case (op)
                    x86s_pkg::OP_NOP, 8'h26, 8'h2e, 8'h36, 8'h3e, 8'h66, 8'h67, 8'hf0,
                    8'hf2, PFX_REP: ;
                    x86s_pkg::OP_CLI: flags_q[9] = 1'b0;
                    x86s_pkg::OP_STI: flags_q[9] = 1'b1;
                    x86s_pkg::OP_JMP: begin
                        m = fetch8();
                        ip_q = ip_q + sext(m);
                    end
                    x86s_pkg::OP_JC: begin
                        m = fetch8();
                        if (flags_q[0]) ip_q = ip_q + sext(m);
                    end
                    x86s_pkg::OP_CALL: begin
                        w = fetch16();
                        push_word(ip_q, dry);
                        ip_q = ip_q + w;
                    end
                    x86s_pkg::OP_PUSHF: push_word(flags_q, dry);
                    x86s_pkg::OP_POPF: flags_q = pop_word();
                    x86s_pkg::OP_MOVRR, x86s_pkg::OP_MOVRS, x86s_pkg::OP_MOVSR: begin
                        m = fetch8();
                        if (m[7:6] != MOD_REG) begin
                            halted_q = 1'b1;
                            r.st = x86s_pkg::ST_UNKNOWN;
                        end else if (op == x86s_pkg::OP_MOVRR) begin
                            gpr[m[5:3]] = gpr[m[2:0]];
                        end else if (op == x86s_pkg::OP_MOVRS) begin
                            gpr[m[2:0]] = seg[m[4:3]];
                        end else begin
                            seg[m[4:3]] = gpr[m[2:0]];
                        end
                    end
                    x86s_pkg::OP_LDAX: begin
                        a = fetch16();
                        w[7:0] = rd8(phys(seg[x86s_pkg::S_DS], a));
                        w[15:8] = rd8(phys(seg[x86s_pkg::S_DS], a + 16'd1));
                        gpr[x86s_pkg::R_AX] = w;
                    end
                    x86s_pkg::OP_OUTIB, x86s_pkg::OP_OUTIW: begin
                        r.port = {8'h00, fetch8()};
                        r.value = (op == x86s_pkg::OP_OUTIB)
                                  ? {8'h00, gpr[x86s_pkg::R_AX][7:0]} : gpr[x86s_pkg::R_AX];
                        r.st = x86s_pkg::ST_PORT;
                    end
                    x86s_pkg::OP_OUTDB, x86s_pkg::OP_OUTDW: begin
                        r.port = gpr[x86s_pkg::R_DX];
                        r.value = (op == x86s_pkg::OP_OUTDB)
                                  ? {8'h00, gpr[x86s_pkg::R_AX][7:0]} : gpr[x86s_pkg::R_AX];
                        r.st = x86s_pkg::ST_PORT;
                    end
                    x86s_pkg::OP_INT: begin
                        r.vec = fetch8();
                        r.st = x86s_pkg::ST_INT;
                    end
                    default: begin
                        halted_q = 1'b1;
                        r.st = x86s_pkg::ST_UNKNOWN;
                    end
                endcase
            end
        end
        r.cs = seg[x86s_pkg::S_CS];
        r.ip = ip_q;
        return r;
    endfunction

    logic [7:0] known_ops[$];

    function automatic logic [7:0] pick_known();
        return known_ops[$urandom_range(0, known_ops.size() - 1)];
    endfunction

    function automatic bit is_known(input logic [7:0] op);
        foreach (known_ops[i]) if (known_ops[i] == op) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int insn_len(input logic [7:0] op);
        if (op[7:3] == GRP_MOVB) return 2;
        if (op[7:3] == GRP_MOVW) return 3;
        case (op)
            x86s_pkg::OP_JMP, x86s_pkg::OP_JC, x86s_pkg::OP_OUTIB, x86s_pkg::OP_OUTIW,
            x86s_pkg::OP_INT, x86s_pkg::OP_MOVRR, x86s_pkg::OP_MOVRS,
            x86s_pkg::OP_MOVSR: return 2;
            x86s_pkg::OP_CALL, x86s_pkg::OP_LDAX: return 3;
            default: return 1;
        endcase
    endfunction

    function automatic int gap_len();
        int n;
        if (quiet) return 0;
        n = $urandom_range(0, 99);
        if (n < 55) return 0;
        if (n < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] pack_item(input logic act, input logic [16:0] addr,
                                              input logic [7:0] data);
        return {6'b0, data, addr, act};
    endfunction

    // Predicts (or takes the typed value), queues it, and drives the transfer.
    task automatic send(input logic [31:0] d, input bit typed, input t_step_result want);
        t_step_result r;
        int g;
        r = run_step(d, 1'b0);
        pending_results.push_back(typed ? want : r);
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic load_byte(input logic [16:0] addr, input logic [7:0] data);
        send(pack_item(ACT_LOAD, addr, data), 1'b0, '0);
    endtask

    // Runs one instruction, first loading any byte it would read that was
    // never written, and replacing an opcode that would halt unless allowed.
    task automatic exec_insn(input bit allow_halt);
        logic [15:0] sg [8], ss_sv [4];
        logic [15:0] ip_sv, fl_sv;
        bit h_sv;
        t_step_result r;
        logic [31:0] d;
        logic [16:0] pc;
        d = pack_item(ACT_EXEC, 17'($urandom), 8'($urandom));
        forever begin
            sg = gpr; ss_sv = seg; ip_sv = ip_q; fl_sv = flags_q; h_sv = halted_q;
            first_miss = -1;
            r = run_step(d, 1'b1);
            gpr = sg; seg = ss_sv; ip_q = ip_sv; flags_q = fl_sv; halted_q = h_sv;
            pc = phys(seg[x86s_pkg::S_CS], ip_q);
            if (first_miss >= 0)
                load_byte(17'(first_miss),
                          (first_miss == int'(pc)) ? pick_known() : 8'($urandom));
            else if (r.st == x86s_pkg::ST_UNKNOWN && !allow_halt)
                load_byte(pc, x86s_pkg::OP_NOP);
            else
                break;
        end
        send(d, 1'b0, '0);
    endtask

    // Writes a fresh instruction with random operands at CS:IP.
    task automatic place_insn(input logic [7:0] op);
        int n;
        logic [7:0] b;
        n = insn_len(op);
        load_byte(phys(seg[x86s_pkg::S_CS], ip_q), op);
        for (int k = 1; k < n; k++) begin
            b = 8'($urandom);
            if ((op == x86s_pkg::OP_MOVRR || op == x86s_pkg::OP_MOVRS
                 || op == x86s_pkg::OP_MOVSR) && $urandom_range(0, 9) > 0)
                b[7:6] = MOD_REG;
            load_byte(phys(seg[x86s_pkg::S_CS], ip_q + 16'(k)), b);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_stall > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_stall <= gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        t_step_result got, want;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.st = x86s_pkg::t_status'(m_axis_tdata[2:0]);
            got.port = m_axis_tdata[18:3];
            got.value = m_axis_tdata[34:19];
            got.vec = m_axis_tdata[42:35];
            got.cs = m_axis_tdata[58:43];
            got.ip = m_axis_tdata[74:59];
            seen_status[m_axis_tdata[2:0]]++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.st !== want.st || got.port !== want.port || got.value !== want.value
                    || got.vec !== want.vec || got.cs !== want.cs || got.ip !== want.ip) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp st %0d port %h val %h vec %h cs %h ip %h, ",
                                  "got st %0d port %h val %h vec %h cs %h ip %h"},
                                 want.st, want.port, want.value, want.vec, want.cs, want.ip,
                                 got.st, got.port, got.value, got.vec, got.cs, got.ip);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    typedef struct {
        logic [31:0]  d;
        bit           typed;
        t_step_result want;
    } t_stim_row;

    t_stim_row rows[$];

    function automatic void add_ld(input logic [16:0] a, input logic [7:0] v);
        t_stim_row t;
        t.d = pack_item(ACT_LOAD, a, v);
        t.typed = 1'b1;
        t.want = '{x86s_pkg::ST_LOADED, 16'h0, 16'h0, 8'h0, 16'h0, 16'h0};
        rows.push_back(t);
    endfunction

    function automatic void add_ex(input bit typed, input x86s_pkg::t_status st,
                                   input logic [15:0] port, input logic [15:0] val,
                                   input logic [7:0] vec, input logic [15:0] ip);
        t_stim_row t;
        t.d = pack_item(ACT_EXEC, 17'h1ffff, 8'hff);
        t.typed = typed;
        t.want = '{st, port, val, vec, 16'h0, ip};
        rows.push_back(t);
    endfunction

    initial begin
        logic [7:0] op;
        logic [15:0] sp0;
        for (int i = 0; i < 256; i++) begin
            op = 8'(i);
            if (op[7:4] == 4'h5 || op[7:4] == 4'hb
                || (op[7:5] == 3'd0 && op[2:1] == 2'b11)
                || op inside {x86s_pkg::OP_NOP, x86s_pkg::OP_CLI, x86s_pkg::OP_STI,
                              x86s_pkg::OP_JMP, x86s_pkg::OP_JC, x86s_pkg::OP_CALL,
                              x86s_pkg::OP_PUSHF, x86s_pkg::OP_POPF, x86s_pkg::OP_MOVRR,
                              x86s_pkg::OP_MOVRS, x86s_pkg::OP_MOVSR, x86s_pkg::OP_LDAX,
                              x86s_pkg::OP_OUTIB, x86s_pkg::OP_OUTIW, x86s_pkg::OP_OUTDB,
                              x86s_pkg::OP_OUTDW, x86s_pkg::OP_INT, 8'h26, 8'h2e, 8'h36,
                              8'h3e, 8'h66, 8'h67, 8'hf0, 8'hf2, PFX_REP})
                known_ops.push_back(op);
        end
        foreach (gpr[i]) gpr[i] = '0;
        foreach (seg[i]) seg[i] = '0;
        gpr[x86s_pkg::R_AX] = x86s_pkg::RESET_AX; gpr[1] = x86s_pkg::RESET_CX;
        gpr[R_BX_TB] = x86s_pkg::RESET_BX;
        gpr[x86s_pkg::R_SP] = x86s_pkg::RESET_SP; gpr[7] = x86s_pkg::RESET_DI;
        seg[x86s_pkg::S_SS] = x86s_pkg::RESET_SS;
        ip_q = '0; flags_q = x86s_pkg::RESET_FL; halted_q = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed program: OUT and INT right after reset, a backward jump
        // that wraps IP, a prefix, an untaken JC and a forward jump that
        // wraps IP back to offset 2.
        add_ld(17'h1ffff, 8'hff);
        add_ld(17'h00000, x86s_pkg::OP_OUTIW); add_ld(17'h00001, 8'h10);
        add_ld(17'h00002, x86s_pkg::OP_OUTDB);
        add_ld(17'h00003, x86s_pkg::OP_INT);   add_ld(17'h00004, 8'hff);
        add_ld(17'h00005, x86s_pkg::OP_PUSHF); add_ld(17'h00006, x86s_pkg::OP_POPF);
        add_ld(17'h00007, x86s_pkg::OP_JMP);   add_ld(17'h00008, 8'h80);
        add_ld(17'h0ff89, PFX_REP);
        add_ld(17'h0ff8a, x86s_pkg::OP_JC);    add_ld(17'h0ff8b, 8'h7f);
        add_ld(17'h0ff8c, x86s_pkg::OP_JMP);   add_ld(17'h0ff8d, 8'h74);
        add_ex(1'b1, x86s_pkg::ST_PORT, 16'h0010, x86s_pkg::RESET_AX, 8'h00, 16'h0002);
        add_ex(1'b1, x86s_pkg::ST_PORT, 16'h0000, {8'h00, x86s_pkg::RESET_AX[7:0]}, 8'h00,
               16'h0003);
        add_ex(1'b1, x86s_pkg::ST_INT, 16'h0, 16'h0, 8'hff, 16'h0005);
        add_ex(1'b0, x86s_pkg::ST_EXEC, 16'h0, 16'h0, 8'h00, 16'h0);
        add_ex(1'b0, x86s_pkg::ST_EXEC, 16'h0, 16'h0, 8'h00, 16'h0);
        add_ex(1'b1, x86s_pkg::ST_EXEC, 16'h0, 16'h0, 8'h00, 16'hff89);
        add_ex(1'b1, x86s_pkg::ST_EXEC, 16'h0, 16'h0, 8'h00, 16'hff8a);
        add_ex(1'b1, x86s_pkg::ST_EXEC, 16'h0, 16'h0, 8'h00, 16'hff8c);
        add_ex(1'b1, x86s_pkg::ST_EXEC, 16'h0, 16'h0, 8'h00, 16'h0002);
        foreach (rows[i]) send(rows[i].d, rows[i].typed, rows[i].want);

        // Well-formed programs with random content, and random loads as noise.
        for (int n = 0; n < RUN_STEPS; n++) begin
            if (n % 200 == 100) quiet = ~quiet;
            if (n == RUN_STEPS / 2) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0: load_byte(17'($urandom), 8'($urandom));
                1, 2: exec_insn(1'b0);
                3: begin
                    // Keep the stack away from the code now and then.
                    sp0 = 16'($urandom);
                    place_insn(OP_MOVW_AX | {5'b0, x86s_pkg::R_SP});
                    load_byte(phys(seg[x86s_pkg::S_CS], ip_q + 16'd1), sp0[7:0]);
                    load_byte(phys(seg[x86s_pkg::S_CS], ip_q + 16'd2), sp0[15:8]);
                    exec_insn(1'b0);
                end
                default: begin
                    op = pick_known();
                    place_insn(op);
                    exec_insn(1'b0);
                end
            endcase
        end

        // Halt at the end: either an unknown opcode or a memory operand form.
        quiet = 1'b0;
        if ($urandom_range(0, 1)) begin
            do op = 8'($urandom); while (is_known(op));
            load_byte(phys(seg[x86s_pkg::S_CS], ip_q), op);
        end else begin
            load_byte(phys(seg[x86s_pkg::S_CS], ip_q), x86s_pkg::OP_MOVRR);
            load_byte(phys(seg[x86s_pkg::S_CS], ip_q + 16'd1),
                      {2'($urandom_range(0, 2)), 6'($urandom)});
        end
        exec_insn(1'b1);
        for (int k = 0; k < 6; k++) begin
            if (k == 3) load_byte(17'($urandom), 8'($urandom));
            else send(pack_item(ACT_EXEC, 17'($urandom), 8'($urandom)), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("results: %0d loads, %0d executed, %0d port writes, %0d interrupts",
                 seen_status[x86s_pkg::ST_LOADED], seen_status[x86s_pkg::ST_EXEC],
                 seen_status[x86s_pkg::ST_PORT], seen_status[x86s_pkg::ST_INT]);
        $display("halt reports: %0d unknown, %0d while halted; %0d mismatches",
                 seen_status[x86s_pkg::ST_UNKNOWN], seen_status[x86s_pkg::ST_HALTED],
                 errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

FILE: x86_subset_instruction_executor.f
rtl/x86s_pkg.sv
rtl/x86s_mem.sv
rtl/x86_subset_instruction_executor.sv
tb/tb_x86_subset_instruction_executor.sv
